/* design/i2cm_pkg.sv */
package i2cm_pkg;

  typedef enum logic [2:0] {
    OP_TICK  = 3'd0,
    OP_START = 3'd1,
    OP_STOP  = 3'd2,
    OP_WRITE = 3'd3,
    OP_READ  = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    CMD_IDLE  = 3'd0,
    CMD_START = 3'd1,
    CMD_STOP  = 3'd2,
    CMD_WRITE = 3'd3,
    CMD_READ  = 3'd4
  } cmd_e;

  localparam int unsigned DataBits = 8;
  localparam logic [4:0] PhaseStartDone = 5'd3;
  localparam logic [4:0] PhaseLastBit   = 5'(2 * DataBits);
  localparam logic [4:0] PhaseLastHigh  = 5'(2 * DataBits + 1);
  localparam logic [4:0] PhaseAck       = 5'(2 * DataBits + 2);
  localparam logic [4:0] PhaseDone      = 5'(2 * DataBits + 3);

  typedef struct packed {
    logic [2:0] op;
    logic [7:0] tx_byte;
    logic       master_ack;
    logic       sda_in;
  } in_word_t;

  typedef struct packed {
    logic       scl_drive_low;
    logic       sda_drive_low;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_received;
    logic       cmd_rejected;
  } res_t;

  typedef struct packed {
    cmd_e       cmd;
    logic [4:0] phase;
    logic [7:0] shift;
    logic       ack;
    logic       want_ack;
    logic       scl;
    logic       sda;
    logic [7:0] rx;
  } seq_state_t;

endpackage

/* design/i2c_master_byte_engine_core.sv */
// Channel | Valid       | Stall        | Word
// in      | in_valid_i  | in_stall_o   | op_i, tx_byte_i, master_ack_i, sda_in_i
// out     | out_valid_o | out_stall_i  | scl/sda_drive_low_o, busy/done_res_o,
//         |             |              | rx_byte_o, ack_received_o, cmd_rejected_o
//
// One word per clock while not stalled; each result is registered after the input register.
// The step logic sits between the input register and the result register.
// rst_ni clears all sequencer state: idle, both pins released, rx byte and ack zero.
// An output stall holds the result register; the input register keeps taking
// words until it is also full.
module i2c_master_byte_engine_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [2:0] op_i,
  input  logic [7:0] tx_byte_i,
  input  logic       master_ack_i,
  input  logic       sda_in_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       scl_drive_low_o,
  output logic       sda_drive_low_o,
  output logic       busy_res_o,
  output logic       done_res_o,
  output logic [7:0] rx_byte_o,
  output logic       ack_received_o,
  output logic       cmd_rejected_o
);

  i2cm_pkg::in_word_t in_word, word;
  i2cm_pkg::res_t     res, res_q;
  logic               out_valid_q, out_valid_d;
  logic               out_free, step_en;

  assign in_word = '{op: op_i, tx_byte: tx_byte_i, master_ack: master_ack_i,
                     sda_in: sda_in_i};
  assign out_free = !out_valid_q || !out_stall_i;

  i2cm_in_reg u_in_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word),
    .down_free_i (out_free),
    .step_en_o   (step_en),
    .word_o      (word)
  );

  i2cm_seq u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_en_i (step_en),
    .word_i    (word),
    .res_o     (res)
  );

  assign out_valid_d = out_free ? step_en : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_en) begin
      res_q <= res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign scl_drive_low_o = res_q.scl_drive_low;
  assign sda_drive_low_o = res_q.sda_drive_low;
  assign busy_res_o      = res_q.busy_res;
  assign done_res_o      = res_q.done_res;
  assign rx_byte_o       = res_q.rx_byte;
  assign ack_received_o  = res_q.ack_received;
  assign cmd_rejected_o  = res_q.cmd_rejected;

`ifndef SYNTHESIS
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && done_res_o |-> !busy_res_o)
    else $error("done word still shows busy");

  a_rej_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && cmd_rejected_o |-> busy_res_o && !done_res_o)
    else $error("rejected word while idle or done");

  a_step_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_en |-> out_free)
    else $error("step taken with result register blocked");
`endif

endmodule

/* design/i2cm_in_reg.sv */
module i2cm_in_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  i2cm_pkg::in_word_t in_word_i,
  input  logic              down_free_i,
  output logic              step_en_o,
  output i2cm_pkg::in_word_t word_o
);

  logic               valid_q, valid_d;
  logic               load;
  i2cm_pkg::in_word_t word_q;

  assign load       = !valid_q || down_free_i;
  assign in_stall_o = !load;
  assign step_en_o  = valid_q && down_free_i;
  assign word_o     = word_q;
  assign valid_d    = load ? in_valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && in_valid_i) begin
      word_q <= in_word_i;
    end
  end

endmodule

/* design/i2cm_seq.sv */
module i2cm_seq (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_en_i,
  input  i2cm_pkg::in_word_t word_i,
  output i2cm_pkg::res_t     res_o
);

  i2cm_pkg::seq_state_t st_q, st_d;
  logic                 done, rej, is_cmd;
  logic [4:0]           p;

  assign is_cmd = (word_i.op >= 3'(i2cm_pkg::OP_START)) &&
                  (word_i.op <= 3'(i2cm_pkg::OP_READ));
  assign p      = st_q.phase + 5'd1;

  // next state
  always_comb begin
    st_d = st_q;
    done = 1'b0;
    rej  = 1'b0;
    if (st_q.cmd == i2cm_pkg::CMD_IDLE) begin
      if (is_cmd) begin
        st_d.phase = '0;
        case (i2cm_pkg::op_e'(word_i.op))
          i2cm_pkg::OP_START: begin
            st_d.cmd = i2cm_pkg::CMD_START;
            st_d.sda = 1'b0;
            st_d.scl = 1'b0;
          end
          i2cm_pkg::OP_STOP: begin
            st_d.cmd = i2cm_pkg::CMD_STOP;
            st_d.sda = 1'b1;
            st_d.scl = 1'b1;
          end
          i2cm_pkg::OP_WRITE: begin
            st_d.cmd   = i2cm_pkg::CMD_WRITE;
            st_d.sda   = ~word_i.tx_byte[7];
            st_d.shift = {word_i.tx_byte[6:0], 1'b0};
          end
          default: begin
            st_d.cmd      = i2cm_pkg::CMD_READ;
            st_d.sda      = 1'b0;
            st_d.shift    = '0;
            st_d.want_ack = word_i.master_ack;
          end
        endcase
      end
    end else if (is_cmd) begin
      rej = 1'b1;
    end else begin
      st_d.phase = p;
      case (st_q.cmd)
        i2cm_pkg::CMD_START: begin
          if (p == 5'd1) st_d.sda = 1'b1;
          else if (p == 5'd2) st_d.scl = 1'b1;
          else done = 1'b1;
        end
        i2cm_pkg::CMD_STOP: begin
          if (p == 5'd1) st_d.scl = 1'b0;
          else if (p == 5'd2) st_d.sda = 1'b0;
          else done = 1'b1;
        end
        i2cm_pkg::CMD_WRITE: begin
          if (p <= i2cm_pkg::PhaseLastHigh && p[0]) begin
            st_d.scl = 1'b0;
          end else if (p <= i2cm_pkg::PhaseLastBit) begin
            st_d.scl = 1'b1;
            if (p < i2cm_pkg::PhaseLastBit) begin
              st_d.sda   = ~st_q.shift[7];
              st_d.shift = {st_q.shift[6:0], 1'b0};
            end else begin
              st_d.sda = 1'b0;
            end
          end else if (p == i2cm_pkg::PhaseAck) begin
            st_d.ack = ~word_i.sda_in;
            st_d.scl = 1'b1;
          end else begin
            done = 1'b1;
          end
        end
        default: begin
          if (p <= i2cm_pkg::PhaseLastHigh && p[0]) begin
            st_d.scl = 1'b0;
          end else if (p <= i2cm_pkg::PhaseLastBit) begin
            st_d.shift = {st_q.shift[6:0], word_i.sda_in};
            st_d.scl   = 1'b1;
            if (p == i2cm_pkg::PhaseLastBit) st_d.sda = st_q.want_ack;
          end else if (p == i2cm_pkg::PhaseAck) begin
            st_d.scl = 1'b1;
          end else begin
            st_d.sda = 1'b0;
            st_d.rx  = st_q.shift;
            done     = 1'b1;
          end
        end
      endcase
      if (done) begin
        st_d.cmd   = i2cm_pkg::CMD_IDLE;
        st_d.phase = '0;
      end
    end
  end

  // result from the updated state
  always_comb begin
    res_o.scl_drive_low = st_d.scl;
    res_o.sda_drive_low = st_d.sda;
    res_o.busy_res      = (st_d.cmd != i2cm_pkg::CMD_IDLE);
    res_o.done_res      = done;
    res_o.rx_byte       = st_d.rx;
    res_o.ack_received  = st_d.ack;
    res_o.cmd_rejected  = rej;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '{cmd: i2cm_pkg::CMD_IDLE, default: '0};
    end else if (step_en_i) begin
      st_q <= st_d;
    end
  end

`ifndef SYNTHESIS
  a_idle_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.cmd == i2cm_pkg::CMD_IDLE |-> st_q.phase == 5'd0)
    else $error("phase count not cleared while idle");

  a_phase_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.phase < i2cm_pkg::PhaseDone)
    else $error("phase count past end of sequence");

  a_short_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q.cmd == i2cm_pkg::CMD_START || st_q.cmd == i2cm_pkg::CMD_STOP)
    |-> st_q.phase < i2cm_pkg::PhaseStartDone)
    else $error("start or stop ran too long");

  a_rej_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_en_i && rej |=> $stable(st_q.phase) && $stable(st_q.cmd))
    else $error("rejected command advanced the sequence");
`endif

endmodule
